/* hdl/adcspi_pkg.sv */
`default_nettype none
// ============================================================================
// adcspi_pkg
// Shared types and constants for the SPI converter slave exchange block.
// ============================================================================
package adcspi_pkg;

    // Field widths of one exchange request and its result.
    localparam int unsigned CountW = 4;
    localparam int unsigned BitsW  = 16;

    // Conversion result queued by a command while running on battery.
    localparam logic [BitsW-1:0] BatteryResult = 16'h0600;

    // Sequencer states, one-hot coded.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

endpackage
`default_nettype wire

/* hdl/adc_spi_slave_exchange.sv */
`default_nettype none
// ============================================================================
// adc_spi_slave_exchange
// Slave side of an SPI converter channel: start-bit framed commands in,
// queued conversion results shifted back one bit per received bit.
// ============================================================================
// Usage:
// - s_ channel: one request is one SPI exchange of 1 to 16 bits. s_tdata
//   carries the bit count minus one and the master's bits, right-aligned.
// - m_ channel: one result per request, the bits the slave returned during
//   that exchange, right-aligned with the first bit most significant.
// - cfg channel: writes the power_connected flag; always ready. Write it only
//   while no request is in flight.
// - Timing: a request of n bits is worked one bit per cycle by a single
//   bit-step unit; if the output register is free, the result is registered
//   at the edge that takes the last bit, which raises m_tvalid. A new request
//   is taken only after the previous one has finished and the block is idle.
// - Stall: the finished result sits in the output register. The next request
//   is still accepted and worked; only if its result is ready while the old
//   one is still held does the block wait until m_tready takes the old one.
// - Reset: aresetn low clears the command state, the output shift register,
//   the queued result and the configuration flag; zeros are sent back until
//   a command completes.
// ============================================================================
module adc_spi_slave_exchange #(
    parameter int unsigned COMMAND_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // power_connected
    // Exchange request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [3:0] bit_count_minus_one, [19:4] mosi_bits
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [15:0] miso_bits
);

    localparam int unsigned CmdW = $clog2(COMMAND_BITS + 1);
    localparam int unsigned CntW = adcspi_pkg::CountW;
    localparam int unsigned BitW = adcspi_pkg::BitsW;

    adcspi_pkg::state_t state_reg, state_next;

    logic                power_reg;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [BitW-1:0]     data_reg, data_next;
    logic [BitW-1:0]     result_reg, result_next;
    logic [BitW-1:0]     shift_reg, shift_next;
    logic [CmdW-1:0]     cmd_reg, cmd_next;
    logic                pend_reg, pend_next;
    logic                pend_zero_reg, pend_zero_next;
    logic                m_valid_reg, m_valid_next;
    logic [BitW-1:0]     m_data_reg, m_data_next;

    logic                rx_bit;
    logic [BitW-1:0]     step_result;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == adcspi_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // The bit under examination, taken MSB first from the request.
    assign rx_bit      = data_reg[cnt_reg];
    assign step_result = {result_reg[BitW-2:0], shift_reg[BitW-1]};
    assign out_free    = !m_valid_reg || m_tready;

    // Sequencer and one-bit exchange step.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        data_next      = data_reg;
        result_next    = result_reg;
        shift_next     = shift_reg;
        cmd_next       = cmd_reg;
        pend_next      = pend_reg;
        pend_zero_next = pend_zero_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            adcspi_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cnt_next    = s_tdata[CntW-1:0];
                    data_next   = s_tdata[CntW +: BitW];
                    result_next = '0;
                    state_next  = adcspi_pkg::ST_RUN;
                end
            end
            adcspi_pkg::ST_RUN: begin
                // One bit out, one bit in.
                result_next = step_result;
                shift_next  = {shift_reg[BitW-2:0], 1'b0};
                if (cmd_reg == '0) begin
                    cmd_next = rx_bit ? CmdW'(1) : '0;
                    if (pend_reg) begin
                        pend_next  = 1'b0;
                        shift_next = pend_zero_reg ? '0 : adcspi_pkg::BatteryResult;
                    end
                end else begin
                    cmd_next = cmd_reg + CmdW'(1);
                end
                // A complete command queues a new conversion result.
                if (cmd_next >= CmdW'(COMMAND_BITS)) begin
                    cmd_next       = '0;
                    pend_next      = 1'b1;
                    pend_zero_next = power_reg;
                end
                if (cnt_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = step_result;
                        state_next   = adcspi_pkg::ST_IDLE;
                    end else begin
                        state_next   = adcspi_pkg::ST_WAIT;
                    end
                end else begin
                    cnt_next = cnt_reg - CntW'(1);
                end
            end
            adcspi_pkg::ST_WAIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = adcspi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = adcspi_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= adcspi_pkg::ST_IDLE;
            power_reg   <= 1'b0;
            shift_reg   <= '0;
            cmd_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            shift_reg   <= shift_next;
            cmd_reg     <= cmd_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                power_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        data_reg      <= data_next;
        result_reg    <= result_next;
        pend_zero_reg <= pend_zero_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTH
    // An accepted request always starts the bit sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == adcspi_pkg::ST_RUN))
        else $error("accepted request did not start the sequencer");

    // The command bit counter never reaches the command length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg < CmdW'(COMMAND_BITS))
        else $error("command counter overran");

    // A finished result waits only while an older one is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == adcspi_pkg::ST_WAIT) |-> m_valid_reg)
        else $error("waiting with an empty output register");
`endif

endmodule
`default_nettype wire
